/* hw/rtl/bpc_pkg.sv */
// Shared types, widths and constants for the barometric compensation core.
package bpc_pkg;

  localparam int RAW_W     = 24;  // raw conversion reading
  localparam int COEFF_W   = 16;  // calibration word
  localparam int CFG_IDX_W = 3;   // register index
  localparam int OUT_W     = 32;  // result fields
  localparam int DT_W      = RAW_W + 1;
  localparam int MUL_W     = 27;  // shared multiplier operand
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 48;  // offset, sensitivity, pressure sum
  localparam int TEMP_W    = 21;  // centi-degrees, before wrap
  localparam int T2_W      = 18;
  localparam int SENS_SPLIT = ACC_W - MUL_W;  // width of the low part of sensitivity

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS   = 3'd5;

  // reading kinds
  localparam logic ACT_TEMP     = 1'b0;
  localparam logic ACT_PRESSURE = 1'b1;

  // temperature thresholds, 0.01 C
  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 21'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -21'sd1500;

  // scaling shifts
  localparam int SH_TEMP  = 23;
  localparam int SH_T2    = 31;
  localparam int SH_OFF   = 7;
  localparam int SH_SENS  = 8;
  localparam int SH_PRESS = 15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DT,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_M7,
    S_PLO,
    S_PHI,
    S_PFIN
  } state_t;

endpackage

/* hw/rtl/baro_pressure_temp_compensation_core.sv */
// Barometric pressure / temperature compensation core, top level.
//
// Input channel (in_valid / in_stall, action, adc_value): one raw reading per
// item. A temperature item (action 0) only records the raw value, skipping a
// zero reading, and is taken at once; in_stall stays low.
// A pressure item (action 1) records a nonzero reading, or reuses the last
// good one, then runs the compensation on a single shared 27x27 signed
// multiplier under a small sequencer. in_stall is high while it works
// through the multiply chain (temperature, offset, sensitivity, two squares
// and a third below 20.00 C, pressure in two partial products); the sequence
// runs longer below 20.00 C and longer again below -15.00 C. The result
// reaches the output channel as in_stall falls, so a new pressure item is
// taken only once the last one is through.
// Output channel (out_valid / out_stall): a result register holds the item
// until taken. Input keeps being accepted while it waits; a finished
// pressure item holds in its last step until the register is free.
// Configuration: cfg_write / cfg_index / cfg_data write one calibration word
// per cycle; indexes above five are ignored. Write only while idle.
// Reset (rst, synchronous) clears calibration words, last readings, the
// sequencer and out_valid.
module baro_pressure_temp_compensation_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::COEFF_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [bpc_pkg::RAW_W-1:0]         adc_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bpc_pkg::OUT_W-1:0]  pressure_pa,
  output logic signed [bpc_pkg::OUT_W-1:0]  temperature_centi_c,
  output logic                              pressure_reused
);
  import bpc_pkg::*;

  state_t state, state_next;

  // calibration words C1..C6
  logic [COEFF_W-1:0] c_sens, c_off, c_sens_t, c_off_t, c_ref_t, c_temp_s;

  logic [RAW_W-1:0] last_pressure_raw, last_temp_raw;
  logic             reused;

  // working registers
  logic signed [DT_W-1:0]   dt;
  logic signed [TEMP_W-1:0] temp;
  logic        [T2_W-1:0]   t2;
  logic signed [ACC_W-1:0]  off, sens, acc;
  logic signed [PROD_W-1:0] prod;

  // shared multiplier
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  logic                     in_accept, out_free;
  logic signed [TEMP_W-1:0] a_val, b_val;
  logic signed [ACC_W-1:0]  sq, sq5_half, sq7, sq11_half, p_sum;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign a_val = temp - TEMP_REF;
  assign b_val = temp - TEMP_COLD;

  // second-order terms from a registered square
  assign sq        = ACC_W'(prod);
  assign sq5_half  = ((sq <<< 2) + sq) >>> 1;
  assign sq7       = (sq <<< 3) - sq;
  assign sq11_half = ((sq <<< 3) + (sq <<< 1) + sq) >>> 1;
  assign p_sum     = acc + ACC_W'(prod) - off;

  // sequencer and multiplier operand select
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (in_accept && action == ACT_PRESSURE) state_next = S_DT;
      end
      S_DT: state_next = S_M1;
      S_M1: begin
        mul_en     = 1'b1;
        mul_a      = MUL_W'(dt);
        mul_b      = $signed(MUL_W'(c_temp_s));
        state_next = S_M2;
      end
      S_M2: begin
        mul_en     = 1'b1;
        mul_a      = $signed(MUL_W'(c_off_t));
        mul_b      = MUL_W'(dt);
        state_next = S_M3;
      end
      S_M3: begin
        mul_en     = 1'b1;
        mul_a      = $signed(MUL_W'(c_sens_t));
        mul_b      = MUL_W'(dt);
        state_next = S_M4;
      end
      S_M4: begin
        mul_en     = 1'b1;
        mul_a      = MUL_W'(dt);
        mul_b      = MUL_W'(dt);
        state_next = S_M5;
      end
      S_M5: begin
        mul_en     = 1'b1;
        mul_a      = MUL_W'(a_val);
        mul_b      = MUL_W'(a_val);
        state_next = (temp < TEMP_REF) ? S_M6 : S_PLO;
      end
      S_M6: begin
        mul_en     = 1'b1;
        mul_a      = MUL_W'(b_val);
        mul_b      = MUL_W'(b_val);
        state_next = (temp < TEMP_COLD) ? S_M7 : S_PLO;
      end
      S_M7: state_next = S_PLO;
      S_PLO: begin
        // low part of the sensitivity, unsigned
        mul_en     = 1'b1;
        mul_a      = $signed(MUL_W'(last_pressure_raw));
        mul_b      = $signed(MUL_W'(sens[SENS_SPLIT-1:0]));
        state_next = S_PHI;
      end
      S_PHI: begin
        mul_en     = 1'b1;
        mul_a      = $signed(MUL_W'(last_pressure_raw));
        mul_b      = sens[ACC_W-1:SENS_SPLIT];
        state_next = S_PFIN;
      end
      S_PFIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration words
  always_ff @(posedge clk) begin
    if (rst) begin
      c_sens   <= '0;
      c_off    <= '0;
      c_sens_t <= '0;
      c_off_t  <= '0;
      c_ref_t  <= '0;
      c_temp_s <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SENS:        c_sens   <= cfg_data;
        REG_OFFSET:      c_off    <= cfg_data;
        REG_SENS_TEMP:   c_sens_t <= cfg_data;
        REG_OFFSET_TEMP: c_off_t  <= cfg_data;
        REG_REF_TEMP:    c_ref_t  <= cfg_data;
        REG_TEMP_SENS:   c_temp_s <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // last good readings; a zero reading keeps the old value
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressure_raw <= '0;
      last_temp_raw     <= '0;
    end else if (in_accept && adc_value != '0) begin
      if (action == ACT_PRESSURE) last_pressure_raw <= adc_value;
      else                        last_temp_raw     <= adc_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) reused <= (adc_value == '0);
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
  end

  // datapath: each step takes the product issued in the step before
  always_ff @(posedge clk) begin
    unique case (state)
      S_DT: dt <= $signed({1'b0, last_temp_raw}) - $signed({1'b0, c_ref_t, 8'b0});
      S_M2: temp <= TEMP_REF + TEMP_W'(prod >>> SH_TEMP);
      S_M3: off  <= $signed(ACC_W'({c_off, 16'b0})) + ACC_W'(prod >>> SH_OFF);
      S_M4: sens <= $signed(ACC_W'({c_sens, 15'b0})) + ACC_W'(prod >>> SH_SENS);
      S_M5: t2   <= prod[SH_T2 +: T2_W];
      S_M6: begin
        off  <= off - sq5_half;
        sens <= sens - (sq5_half >>> 1);
        temp <= temp - $signed(TEMP_W'(t2));
      end
      S_M7: begin
        off  <= off - sq7;
        sens <= sens - sq11_half;
      end
      S_PHI: acc <= ACC_W'(prod >>> SENS_SPLIT);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_PFIN && out_free) begin
      pressure_pa         <= OUT_W'(p_sum >>> SH_PRESS);
      temperature_centi_c <= OUT_W'(temp);
      pressure_reused     <= reused;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PFIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/bpc_checker.sv */
// Port-level checks for the compensation core, bound to the top level.
module bpc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              action,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bpc_pkg::OUT_W-1:0]  pressure_pa,
  input logic signed [bpc_pkg::OUT_W-1:0]  temperature_centi_c,
  input logic                              pressure_reused
);
  import bpc_pkg::*;

  // temperature items never make the core busy
  a_temp_no_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_TEMP |=> !in_stall)
    else $error("core busy after temperature item");

  // a pressure item starts the sequence
  a_press_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_PRESSURE |=> in_stall)
    else $error("core not busy after pressure item");

  // after reset the core is idle with no pending result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressure_pa)
      && $stable(temperature_centi_c) && $stable(pressure_reused))
    else $error("stalled result changed");

endmodule

bind baro_pressure_temp_compensation_core bpc_checker u_bpc_checker (.*);
